FILE: src/itp_pkg.sv
// Shared types, codes and operator tables for the infix-to-postfix converter.
// No dependencies; used by the front, queue, back and top-level files.
`default_nettype none

package itp_pkg;

  // Operator codes as they are held on the operator stack
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LPAREN = 3'd1,
    OP_CARET  = 3'd2,
    OP_DOLLAR = 3'd3,
    OP_STAR   = 3'd4,
    OP_SLASH  = 3'd5,
    OP_PLUS   = 3'd6,
    OP_MINUS  = 3'd7
  } op_code_t;

  // Character classes decided by the front end
  typedef enum logic [2:0] {
    K_IGNORE,
    K_PASS,
    K_OPEN,
    K_BINOP,
    K_CLOSE
  } sym_kind_t;

  // One classified request as it travels from front to back
  typedef struct packed {
    sym_kind_t  kind;
    op_code_t   code;
    logic [7:0] sym;
    logic       last;
  } item_t;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // ASCII characters of interest
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Precedence: power 3, multiplicative 2, additive 1, parenthesis 0
  function automatic logic [1:0] op_rank(input op_code_t code);
    logic [1:0] rank;
    case (code)
      OP_CARET, OP_DOLLAR: rank = 2'd3;
      OP_STAR, OP_SLASH:   rank = 2'd2;
      OP_PLUS, OP_MINUS:   rank = 2'd1;
      default:             rank = 2'd0;
    endcase
    return rank;
  endfunction

  // Character written out when an operator is popped
  function automatic logic [7:0] op_char(input op_code_t code);
    logic [7:0] ch;
    case (code)
      OP_LPAREN: ch = CH_LPAREN;
      OP_CARET:  ch = CH_CARET;
      OP_DOLLAR: ch = CH_DOLLAR;
      OP_STAR:   ch = CH_STAR;
      OP_SLASH:  ch = CH_SLASH;
      OP_PLUS:   ch = CH_PLUS;
      OP_MINUS:  ch = CH_MINUS;
      default:   ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: src/itp_front.sv
// Front end: accepts input requests and classifies each character.
// Depends on itp_pkg; feeds itp_queue.
`default_nettype none

module itp_front (
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    symbol,
  input  wire logic          end_of_expr,
  input  wire logic          q_ready,
  output logic               q_push,
  output itp_pkg::item_t     q_item
);

  logic is_alnum;

  // Request handshake follows queue room
  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  assign is_alnum = (symbol >= 8'h41 && symbol <= 8'h5A) ||
                    (symbol >= 8'h61 && symbol <= 8'h7A) ||
                    (symbol >= 8'h30 && symbol <= 8'h39);

  // Classify the character
  always_comb begin
    q_item.sym  = symbol;
    q_item.last = end_of_expr;
    q_item.code = itp_pkg::OP_NONE;
    q_item.kind = itp_pkg::K_IGNORE;
    if (is_alnum) begin
      q_item.kind = itp_pkg::K_PASS;
    end else begin
      case (symbol)
        itp_pkg::CH_LPAREN: begin
          q_item.kind = itp_pkg::K_OPEN;
          q_item.code = itp_pkg::OP_LPAREN;
        end
        itp_pkg::CH_CARET: begin
          q_item.kind = itp_pkg::K_OPEN;
          q_item.code = itp_pkg::OP_CARET;
        end
        itp_pkg::CH_DOLLAR: begin
          q_item.kind = itp_pkg::K_OPEN;
          q_item.code = itp_pkg::OP_DOLLAR;
        end
        itp_pkg::CH_STAR: begin
          q_item.kind = itp_pkg::K_BINOP;
          q_item.code = itp_pkg::OP_STAR;
        end
        itp_pkg::CH_SLASH: begin
          q_item.kind = itp_pkg::K_BINOP;
          q_item.code = itp_pkg::OP_SLASH;
        end
        itp_pkg::CH_PLUS: begin
          q_item.kind = itp_pkg::K_BINOP;
          q_item.code = itp_pkg::OP_PLUS;
        end
        itp_pkg::CH_MINUS: begin
          q_item.kind = itp_pkg::K_BINOP;
          q_item.code = itp_pkg::OP_MINUS;
        end
        itp_pkg::CH_RPAREN: begin
          q_item.kind = itp_pkg::K_CLOSE;
        end
        default: begin
          q_item.kind = itp_pkg::K_IGNORE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/itp_queue.sv
// Short queue of classified requests between front and back.
// Depends on itp_pkg.
`default_nettype none

module itp_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire itp_pkg::item_t push_item,
  output logic                not_full,
  input  wire logic           pop,
  output logic                head_valid,
  output itp_pkg::item_t      head_item
);

  localparam int PW = (itp_pkg::QUEUE_DEPTH > 1) ? $clog2(itp_pkg::QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(itp_pkg::QUEUE_DEPTH + 1);

  itp_pkg::item_t entries [itp_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [NW-1:0]  fill;
  logic           do_push;
  logic           do_pop;

  assign not_full   = fill != NW'(itp_pkg::QUEUE_DEPTH);
  assign head_valid = fill != '0;
  assign head_item  = entries[rd_ptr];
  assign do_push    = push && not_full;
  assign do_pop     = pop && head_valid;

  // Pointer wrap
  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    logic [PW-1:0] n;
    if (p == PW'(itp_pkg::QUEUE_DEPTH - 1)) n = '0;
    else n = p + PW'(1);
    return n;
  endfunction

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= next_ptr(wr_ptr);
      if (do_pop) rd_ptr <= next_ptr(rd_ptr);
      if (do_push && !do_pop) fill <= fill + NW'(1);
      else if (do_pop && !do_push) fill <= fill - NW'(1);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

FILE: src/itp_back.sv
// Back end: operator stack, pop sequencer, result staging and output register.
// Depends on itp_pkg; reads classified requests from itp_queue.
`default_nettype none

module itp_back #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire itp_pkg::item_t q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_char,
  output logic                run_last,
  output logic                expr_done,
  output logic                overflow_seen,
  output logic                unmatched_close
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic {S_MAIN, S_FLUSH} state_t;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic          ovf, ovf_next;
  logic          unm, unm_next;

  // Operator stack memory, with the top entry held in a registered read port
  itp_pkg::op_code_t stack_mem [STACK_DEPTH];
  itp_pkg::op_code_t top;

  // Pending result, held until it is known whether more follow for its request
  logic       p_valid;
  logic [7:0] p_char;
  logic       p_done;
  logic       p_ovf;
  logic       p_unm;
  logic       p_final;

  logic              push, pop, after_op, want, fin;
  itp_pkg::op_code_t push_code;
  logic [7:0]        r_char;
  logic              r_done;
  logic              emit_ok, can_prod, produce, p_move;
  logic              not_empty, full;
  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [CW-1:0]     rd_full;

  assign not_empty = count != '0;
  assign full      = count == CW'(STACK_DEPTH);
  assign emit_ok   = !out_valid || out_ready;
  assign can_prod  = !p_valid || emit_ok;

  // Sequencer: one push or one pop per cycle
  always_comb begin
    state_next = state;
    ovf_next   = ovf;
    unm_next   = unm;
    push       = 1'b0;
    pop        = 1'b0;
    push_code  = q_item.code;
    after_op   = 1'b0;
    want       = 1'b0;
    fin        = 1'b0;
    r_char     = itp_pkg::CH_NUL;
    r_done     = 1'b0;
    case (state)
      S_MAIN: begin
        if (q_valid) begin
          case (q_item.kind)
            itp_pkg::K_PASS: begin
              want   = 1'b1;
              r_char = q_item.sym;
              if (can_prod) begin
                if (q_item.last) state_next = S_FLUSH;
                else fin = 1'b1;
              end
            end
            itp_pkg::K_OPEN: begin
              push     = 1'b1;
              after_op = 1'b1;
            end
            itp_pkg::K_BINOP: begin
              if (not_empty && (itp_pkg::op_rank(q_item.code) <= itp_pkg::op_rank(top)))
              begin
                want   = 1'b1;
                r_char = itp_pkg::op_char(top);
                pop    = can_prod;
              end else begin
                push     = 1'b1;
                after_op = 1'b1;
              end
            end
            itp_pkg::K_CLOSE: begin
              if (not_empty && top != itp_pkg::OP_LPAREN) begin
                want   = 1'b1;
                r_char = itp_pkg::op_char(top);
                pop    = can_prod;
              end else begin
                if (not_empty) pop = 1'b1;
                else unm_next = 1'b1;
                after_op = 1'b1;
              end
            end
            default: begin
              after_op = 1'b1;
            end
          endcase
          if (after_op) begin
            if (q_item.last) state_next = S_FLUSH;
            else fin = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        want = 1'b1;
        if (not_empty) begin
          r_char = itp_pkg::op_char(top);
          pop    = can_prod;
        end else begin
          r_done = 1'b1;
          if (can_prod) begin
            fin        = 1'b1;
            ovf_next   = 1'b0;
            unm_next   = 1'b0;
            state_next = S_MAIN;
          end
        end
      end
      default: begin
        state_next = S_MAIN;
      end
    endcase

    // Stack pointer update; a push onto a full stack is dropped
    count_next = count;
    wr_en      = 1'b0;
    if (push) begin
      if (full) ovf_next = 1'b1;
      else begin
        count_next = count + CW'(1);
        wr_en      = 1'b1;
      end
    end else if (pop) begin
      count_next = count - CW'(1);
    end
  end

  assign produce = want && can_prod;
  assign p_move  = p_valid && emit_ok && (p_final || produce);
  assign q_pop   = fin;
  assign wr_addr = count[AW-1:0];
  assign rd_full = count_next - CW'(1);
  assign rd_addr = rd_full[AW-1:0];

  // Stack memory with write-through to the top register
  always_ff @(posedge clk) begin
    if (wr_en) stack_mem[wr_addr] <= push_code;
    if (wr_en && wr_addr == rd_addr) top <= push_code;
    else top <= stack_mem[rd_addr];
  end

  // State, pending stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_MAIN;
      count     <= '0;
      ovf       <= 1'b0;
      unm       <= 1'b0;
      p_valid   <= 1'b0;
      p_final   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
      unm   <= unm_next;

      if (produce) begin
        p_valid <= 1'b1;
        p_char  <= r_char;
        p_done  <= r_done;
        p_ovf   <= r_done && ovf;
        p_unm   <= r_done && unm;
        p_final <= fin;
      end else if (p_move) begin
        p_valid <= 1'b0;
      end else if (fin && p_valid) begin
        p_final <= 1'b1;
      end

      if (p_move) begin
        out_valid       <= 1'b1;
        out_char        <= p_char;
        expr_done       <= p_done;
        overflow_seen   <= p_ovf;
        unmatched_close <= p_unm;
        run_last        <= p_final;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/infix_to_postfix_converter_top.sv
// Infix-to-postfix converter (shunting-yard), top level.
// Depends on itp_pkg, itp_front, itp_queue and itp_back.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one ASCII character per request in
//   symbol; end_of_expr marks the last character of an expression.
//   Output channel (out_valid/out_ready) delivers postfix characters in
//   out_char. run_last flags the last result caused by one input request.
//   After the last character the operator stack is flushed and a terminator
//   (expr_done=1, out_char=0) reports overflow_seen and unmatched_close.
// Timing:
//   The front classifies and queues requests (2 deep), so input is taken
//   while the back works. The back takes each request in turn, pops each
//   operator in its own step and ends with a terminator step; a letter or
//   digit passes the queue, staging and output registers. The stack's one
//   push or one pop per cycle sets the rate unless the output stalls.
// Reset clears the stack, flags, queue and output register. When out_ready is
//   low, one result waits in the output register and one in a staging
//   register; the back then stops and the queue fills before in_ready drops.
`default_nettype none

module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] symbol,
  input  wire logic       end_of_expr,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            run_last,
  output logic            expr_done,
  output logic            overflow_seen,
  output logic            unmatched_close
);

  logic           q_ready;
  logic           q_push;
  itp_pkg::item_t q_in_item;
  logic           q_head_valid;
  itp_pkg::item_t q_head_item;
  logic           q_pop;

  // Classification
  itp_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .symbol      (symbol),
    .end_of_expr (end_of_expr),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_item      (q_in_item)
  );

  // Decoupling queue
  itp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_in_item),
    .not_full   (q_ready),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head_item)
  );

  // Stack engine and output
  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_head_valid),
    .q_item          (q_head_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .run_last        (run_last),
    .expr_done       (expr_done),
    .overflow_seen   (overflow_seen),
    .unmatched_close (unmatched_close)
  );

endmodule

`default_nettype wire

FILE: src/itp_checker.sv
// Port-level checks for the infix-to-postfix converter, bound to the top level.
// No package dependencies.
`default_nettype none

module itp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic       run_last,
  input wire logic       expr_done,
  input wire logic       overflow_seen,
  input wire logic       unmatched_close
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(run_last)
      && $stable(expr_done))
    else $error("output changed while stalled");

  // Terminator ends its request and carries a zero character
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && expr_done |-> run_last && out_char == 8'h00)
    else $error("terminator malformed");

  // Flags appear only on the terminator
  a_flags_term: assert property (@(posedge clk) disable iff (rst)
    out_valid && !expr_done |-> !overflow_seen && !unmatched_close)
    else $error("flag outside terminator");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind infix_to_postfix_converter_top itp_checker u_itp_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_char        (out_char),
  .run_last        (run_last),
  .expr_done       (expr_done),
  .overflow_seen   (overflow_seen),
  .unmatched_close (unmatched_close)
);

`default_nettype wire

FILE: bench/tb_infix_to_postfix_converter_top.sv
`timescale 1ns / 100ps
// Self-checking bench for infix_to_postfix_converter_top: directed and random
// infix requests, with outputs checked against a shunting-yard predictor.
// Depends on itp_pkg and the converter RTL.

module tb_infix_to_postfix_converter_top;

  localparam int STACK_DEPTH = 32;
  localparam int CYCLE_LIMIT = 250000;

  // One postfix result as seen on the output channel
  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       done;
    logic       ovf;
    logic       unm;
  } postfix_result_t;

  // Predicts postfix output and keeps the expected results in order
  class postfix_scoreboard;
    itp_pkg::op_code_t held_ops [STACK_DEPTH];
    int unsigned       held_count;
    bit                overflow_hit;
    bit                close_unmatched;
    postfix_result_t   awaited [$];
    int unsigned       failures;
    logic [7:0]        glyph [8];

    function new();
      held_count = 0;
      overflow_hit = 0;
      close_unmatched = 0;
      failures = 0;
      glyph = '{itp_pkg::CH_NUL, itp_pkg::CH_LPAREN, itp_pkg::CH_CARET,
                itp_pkg::CH_DOLLAR, itp_pkg::CH_STAR, itp_pkg::CH_SLASH,
                itp_pkg::CH_PLUS, itp_pkg::CH_MINUS};
    endfunction

    function itp_pkg::op_code_t code_of(logic [7:0] sym);
      case (sym)
        itp_pkg::CH_LPAREN: return itp_pkg::OP_LPAREN;
        itp_pkg::CH_CARET:  return itp_pkg::OP_CARET;
        itp_pkg::CH_DOLLAR: return itp_pkg::OP_DOLLAR;
        itp_pkg::CH_STAR:   return itp_pkg::OP_STAR;
        itp_pkg::CH_SLASH:  return itp_pkg::OP_SLASH;
        itp_pkg::CH_PLUS:   return itp_pkg::OP_PLUS;
        itp_pkg::CH_MINUS:  return itp_pkg::OP_MINUS;
        default:            return itp_pkg::OP_NONE;
      endcase
    endfunction

    function int unsigned weight(itp_pkg::op_code_t code);
      if (code == itp_pkg::OP_CARET || code == itp_pkg::OP_DOLLAR) return 3;
      if (code == itp_pkg::OP_STAR || code == itp_pkg::OP_SLASH) return 2;
      if (code == itp_pkg::OP_PLUS || code == itp_pkg::OP_MINUS) return 1;
      return 0;
    endfunction

    function bit is_alnum(logic [7:0] sym);
      return (sym >= "A" && sym <= "Z") || (sym >= "a" && sym <= "z") ||
             (sym >= "0" && sym <= "9");
    endfunction

    function void emit(logic [7:0] ch, logic done);
      postfix_result_t r;
      r.ch = ch;
      r.run_last = 1'b0;
      r.done = done;
      r.ovf = done & overflow_hit;
      r.unm = done & close_unmatched;
      awaited.push_back(r);
    endfunction

    function void push_op(itp_pkg::op_code_t code);
      if (held_count >= STACK_DEPTH) begin
        overflow_hit = 1;
      end else begin
        held_ops[held_count] = code;
        held_count++;
      end
    endfunction

    function void pop_op();
      held_count--;
      emit(glyph[held_ops[held_count]], 1'b0);
    endfunction

    // Work out the results caused by one accepted request
    function void note_request(logic [7:0] sym, logic last);
      itp_pkg::op_code_t code;
      int                start;
      postfix_result_t   tail;
      code = code_of(sym);
      start = awaited.size();
      if (is_alnum(sym)) begin
        emit(sym, 1'b0);
      end else if (code == itp_pkg::OP_LPAREN || code == itp_pkg::OP_CARET ||
                   code == itp_pkg::OP_DOLLAR) begin
        push_op(code);
      end else if (code != itp_pkg::OP_NONE) begin
        while (held_count > 0 && weight(code) <= weight(held_ops[held_count - 1]))
          pop_op();
        push_op(code);
      end else if (sym == itp_pkg::CH_RPAREN) begin
        while (held_count > 0 && held_ops[held_count - 1] != itp_pkg::OP_LPAREN)
          pop_op();
        if (held_count > 0) held_count--;
        else close_unmatched = 1;
      end
      // flush and terminator; flags clear after being reported
      if (last) begin
        while (held_count > 0)
          pop_op();
        emit(itp_pkg::CH_NUL, 1'b1);
        overflow_hit = 0;
        close_unmatched = 0;
      end
      if (awaited.size() > start) begin
        tail = awaited[awaited.size() - 1];
        tail.run_last = 1'b1;
        awaited[awaited.size() - 1] = tail;
      end
    endfunction

    // Compare one output result with the oldest expectation
    function void check_result(postfix_result_t got);
      postfix_result_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: char=%h last=%b done=%b ovf=%b unm=%b",
                   got.ch, got.run_last, got.done, got.ovf, got.unm);
      end else begin
        want = awaited.pop_front();
        if (got.ch !== want.ch || got.run_last !== want.run_last ||
            got.done !== want.done || got.ovf !== want.ovf || got.unm !== want.unm) begin
          failures++;
          if (failures <= 10)
            $display({"mismatch: exp char=%h last=%b done=%b ovf=%b unm=%b,",
                      " got char=%h last=%b done=%b ovf=%b unm=%b"},
                     want.ch, want.run_last, want.done, want.ovf, want.unm,
                     got.ch, got.run_last, got.done, got.ovf, got.unm);
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] symbol;
  logic       end_of_expr;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char;
  logic       run_last;
  logic       expr_done;
  logic       overflow_seen;
  logic       unmatched_close;

  postfix_scoreboard sb;
  int unsigned       items_sent;
  int unsigned       cycles;
  bit                quiet;

  infix_to_postfix_converter_top #(.STACK_DEPTH(STACK_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .symbol(symbol),
    .end_of_expr(end_of_expr),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char(out_char),
    .run_last(run_last),
    .expr_done(expr_done),
    .overflow_seen(overflow_seen),
    .unmatched_close(unmatched_close)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Known values from time zero
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    symbol = 8'h00;
    end_of_expr = 1'b0;
    out_ready = 1'b0;
    quiet = 1'b0;
    items_sent = 0;
    cycles = 0;
    sb = new();
  end

  // Random idle, about 9 draws in 100 unless in the quiet stretch
  function bit take_gap();
    return !quiet && ($urandom_range(0, 99) < 9);
  endfunction

  // Receiver stalls
  always @(negedge clk) begin
    out_ready = !take_gap();
  end

  // Check each accepted result
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({out_char, run_last, expr_done, overflow_seen, unmatched_close});
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Drive one request and wait for its acceptance
  task automatic send_symbol(input logic [7:0] ch, input logic last);
    @(negedge clk);
    while (take_gap()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    symbol = ch;
    end_of_expr = last;
    do @(posedge clk); while (!in_ready);
    sb.note_request(ch, last);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++)
      send_symbol(s[i], i == s.len() - 1);
  endtask

  task automatic send_list(ref logic [7:0] expr [$]);
    int i;
    for (i = 0; i < expr.size(); i++)
      send_symbol(expr[i], i == expr.size() - 1);
  endtask

  // Sender idles until every expected result has come
  task automatic drain_outputs();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.awaited.size() > 0)
      @(posedge clk);
  endtask

  function logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return 8'("A" + $urandom_range(0, 25));
      1:       return 8'("a" + $urandom_range(0, 25));
      default: return 8'("0" + $urandom_range(0, 9));
    endcase
  endfunction

  // Balanced expression with random operands, operators and nesting
  task automatic send_wellformed();
    logic [7:0] expr [$];
    string      ops;
    int         terms;
    int         open_now;
    int         k;
    ops = "+-*/^$";
    terms = $urandom_range(1, 6);
    open_now = 0;
    for (k = 0; k < terms; k++) begin
      if (k > 0) expr.push_back(ops[$urandom_range(0, 5)]);
      if ($urandom_range(0, 9) == 0) expr.push_back(" ");
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) begin
        expr.push_back(itp_pkg::CH_LPAREN);
        open_now++;
      end
      expr.push_back(rand_operand());
      if (open_now > 0 && $urandom_range(0, 2) == 0) begin
        expr.push_back(itp_pkg::CH_RPAREN);
        open_now--;
      end
    end
    while (open_now > 0) begin
      expr.push_back(itp_pkg::CH_RPAREN);
      open_now--;
    end
    // sometimes end on an ignored character
    if ($urandom_range(0, 7) == 0) expr.push_back(" ");
    send_list(expr);
  endtask

  // Random tokens with unbalanced parentheses likely
  task automatic send_broken();
    logic [7:0] expr [$];
    string      pool;
    pool = "ab9()()+-*/^$ ";
    repeat ($urandom_range(2, 8))
      expr.push_back(pool[$urandom_range(0, pool.len() - 1)]);
    send_list(expr);
  endtask

  // Arbitrary bytes
  task automatic send_noise();
    logic [7:0] expr [$];
    repeat ($urandom_range(1, 6))
      expr.push_back(8'($urandom_range(0, 255)));
    send_list(expr);
  endtask

  // More pushes than the stack holds, then a full flush
  task automatic send_deep();
    logic [7:0] expr [$];
    string      pool;
    pool = "(^$";
    expr.push_back(rand_operand());
    repeat (STACK_DEPTH + 2)
      expr.push_back(pool[$urandom_range(0, 2)]);
    expr.push_back(rand_operand());
    send_list(expr);
  endtask

  // Stimulus
  initial begin
    int pick;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: letter and digit extremes, every operator, special cases
    send_text("A+Z*0/9");
    send_text("(a-z)^b$c");
    send_text(")");                 // close on empty stack
    send_text("( ");                // unmatched open, last on ignored char
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b1);
    drain_outputs();

    // random expressions
    send_deep();
    while (items_sent < 225) begin
      quiet = (items_sent >= 110 && items_sent < 170);
      pick = $urandom_range(0, 99);
      if (pick < 68) send_wellformed();
      else if (pick < 80) send_broken();
      else if (pick < 94) send_noise();
      else send_deep();
      if ($urandom_range(0, 19) == 0) drain_outputs();
    end
    quiet = 1'b0;

    @(negedge clk);
    in_valid = 1'b0;
    drain_outputs();
    repeat (16) @(posedge clk);
    if (sb.failures == 0 && sb.awaited.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
